FILE: sv/jcws_pkg.sv
// ----------------------------------------------------------------------------
// jcws_pkg: shared types, constants and functions for the script stripper
// Character codes, comment mode encoding, the per-byte judge function and
// the result group that passes from the core to the output buffer.
// ----------------------------------------------------------------------------
package jcws_pkg;

  localparam int COUNT_BITS_DEFAULT = 32;
  localparam int MAX_RESULTS        = 4;
  localparam int RES_CNT_BITS       = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_ASCII_TOP = 8'd126;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_BSLASH    = 8'h5C;
  localparam logic [7:0] CH_NUL       = 8'h00;

  typedef enum logic [1:0] {
    CM_NONE  = 2'd0,
    CM_LINE  = 2'd1,
    CM_BLOCK = 2'd2
  } cmode_t;

  // Scan state that one judged byte reads and updates
  typedef struct packed {
    logic [7:0] before_char;
    cmode_t     mode;
    logic       last_was_brace;
  } jstate_t;

  typedef struct packed {
    jstate_t st;
    logic    ins_nl;
    logic    emit;
  } judge_t;

  // One item's worth of results, slot 0 first
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] chars;
    logic [MAX_RESULTS-1:0]      cv;
    logic [RES_CNT_BITS-1:0]     n;
    logic                        done;
    logic [31:0]                 total;
    logic [31:0]                 kept;
  } jcws_group_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alnum(c) || c == CH_UNDER || c == CH_PLUS || c == CH_DOLLAR ||
           c == CH_BSLASH || c > CH_ASCII_TOP;
  endfunction

  // Judge one byte with its lookahead: comment tracking and keep/drop
  function automatic judge_t judge(input jstate_t s, input logic [7:0] cur,
                                   input logic [7:0] nxt);
    judge_t r;
    logic   skip;
    r        = '{st: s, ins_nl: 1'b0, emit: 1'b0};
    skip     = 1'b0;
    if (r.st.mode == CM_NONE && cur == CH_SLASH) begin
      if (nxt == CH_SLASH) begin
        r.st.mode = CM_LINE;
      end else if (nxt == CH_STAR) begin
        r.st.mode = CM_BLOCK;
      end
    end
    if (r.st.mode == CM_NONE) begin
      skip = (cur == CH_SPACE && nxt == CH_SPACE);
      if (!skip && cur != CH_LF && cur != CH_CR && cur != CH_TAB) begin
        if (cur == CH_SPACE && (!is_word(nxt) || !is_word(s.before_char))) begin
          skip = 1'b1;
        end
        if (!skip) begin
          r.ins_nl            = s.last_was_brace && is_alnum(cur);
          r.st.last_was_brace = (cur == CH_RBRACE);
          r.emit              = 1'b1;
        end
      end
    end
    if (r.st.mode == CM_LINE && cur == CH_LF) begin
      r.st.mode = CM_NONE;
    end
    if (r.st.mode == CM_BLOCK && cur == CH_SLASH && s.before_char == CH_STAR) begin
      r.st.mode = CM_NONE;
    end
    r.st.before_char = (cur == CH_LF) ? CH_SPACE : cur;
    return r;
  endfunction

endpackage

FILE: sv/jcws_if.sv
// ----------------------------------------------------------------------------
// jcws stream interfaces
// Valid/ready channels for raw input bytes and for stripped result items.
// ----------------------------------------------------------------------------
interface jcws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_file;

  modport source (output valid, output in_char, output end_of_file, input ready);
  modport sink (input valid, input in_char, input end_of_file, output ready);
endinterface

interface jcws_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        last_of_run;
  logic        file_done;
  logic [31:0] total_count;
  logic [31:0] kept_count;

  modport source (output valid, output out_char, output char_valid,
                  output last_of_run, output file_done, output total_count,
                  output kept_count, input ready);
  modport sink (input valid, input out_char, input char_valid,
                input last_of_run, input file_done, input total_count,
                input kept_count, output ready);
endinterface

FILE: sv/js_comment_whitespace_stripper_top.sv
// ----------------------------------------------------------------------------
// js_comment_whitespace_stripper_top: streaming script comment/space stripper
// ----------------------------------------------------------------------------
// Takes one byte of script text per item and writes the stripped text, one
// byte per result item, followed at end of file by one count item that
// carries the saturating total and kept byte counts. Each byte is judged when
// the next byte arrives, so results lag the input by one byte; the final byte
// of a file is flushed with its end_of_file item. An item that yields zero or
// one result does not hold off the next item, so plain text streams at one
// byte per clock while the output is ready; an item that yields more results
// (up to four) occupies the output register until its last result leaves and
// holds off input until that result is leaving. Throughput is set by the
// output register, which drains one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module js_comment_whitespace_stripper_top import jcws_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  jcws_in_if.sink       in_stream,
  jcws_out_if.source    out_stream
);

  jcws_group_t grp;
  logic        grp_load;
  logic        load_ok;

  // Lookahead, scan state and result packing
  jcws_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .in_ready (in_stream.ready),
    .in_char  (in_stream.in_char),
    .in_eof   (in_stream.end_of_file),
    .load_ok  (load_ok),
    .grp      (grp),
    .grp_load (grp_load)
  );

  // Result register, one item per cycle while the output is ready
  jcws_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .grp         (grp),
    .grp_load    (grp_load),
    .load_ok     (load_ok),
    .out_valid   (out_stream.valid),
    .out_ready   (out_stream.ready),
    .out_char    (out_stream.out_char),
    .char_valid  (out_stream.char_valid),
    .last_of_run (out_stream.last_of_run),
    .file_done   (out_stream.file_done),
    .total_count (out_stream.total_count),
    .kept_count  (out_stream.kept_count)
  );

endmodule

FILE: sv/jcws_core.sv
// ----------------------------------------------------------------------------
// jcws_core: input register, one-byte lookahead and scan state
// Judges the held byte against the registered byte, and on end of file the
// registered byte against the closing newline, then hands a packed result group
// to the output buffer.
// ----------------------------------------------------------------------------
module jcws_core import jcws_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_eof,
  input  logic        load_ok,
  output jcws_group_t grp,
  output logic        grp_load
);

  localparam int CW1 = COUNT_BITS + 1;
  localparam int NCAND = MAX_RESULTS + 1;

  logic [7:0]            ir_char;
  logic                  ir_eof;
  logic                  ir_valid;
  logic [7:0]            held_char;
  logic                  held_valid;
  jstate_t               scan;
  logic [COUNT_BITS-1:0] bytes_seen;
  logic [COUNT_BITS-1:0] bytes_kept;

  judge_t                j1;
  judge_t                j2;
  jstate_t               s1;
  logic                  fire;
  logic [1:0]            seen_inc;
  logic [1:0]            kept_inc;
  logic [CW1-1:0]        seen_sum;
  logic [CW1-1:0]        kept_sum;
  logic [COUNT_BITS-1:0] bytes_seen_next;
  logic [COUNT_BITS-1:0] bytes_kept_next;
  logic [63:0]           seen_ext;
  logic [63:0]           kept_ext;
  logic [NCAND-1:0][7:0] cand_char;
  logic [NCAND-1:0]      cand_cv;
  logic [NCAND-1:0]      cand_en;
  logic [2:0]            pos;

  // Judge the held byte, then on end of file the last byte itself
  always_comb begin
    j1 = judge(scan, held_char, (held_char == CH_LF) ? CH_SPACE : ir_char);
    s1 = held_valid ? j1.st : scan;
    j2 = judge(s1, ir_char, (ir_char == CH_LF) ? CH_SPACE : CH_LF);
  end

  // Saturating counts; the closing newline counts as seen but never kept
  always_comb begin
    seen_inc = 2'(held_valid) + 2'(ir_eof) + 2'(ir_eof && ir_char != CH_LF);
    kept_inc = 2'(held_valid && j1.emit) + 2'(ir_eof && j2.emit);
    seen_sum = {1'b0, bytes_seen} + CW1'(seen_inc);
    kept_sum = {1'b0, bytes_kept} + CW1'(kept_inc);
    bytes_seen_next = seen_sum[COUNT_BITS] ? '1 : seen_sum[COUNT_BITS-1:0];
    bytes_kept_next = kept_sum[COUNT_BITS] ? '1 : kept_sum[COUNT_BITS-1:0];
    seen_ext = 64'(bytes_seen_next);
    kept_ext = 64'(bytes_kept_next);
  end

  // Pack inserted newlines, kept bytes and the count item into slots
  always_comb begin
    cand_char = {CH_NUL, ir_char, CH_LF, held_char, CH_LF};
    cand_cv   = 5'b01111;
    cand_en   = {ir_eof, ir_eof && j2.emit, ir_eof && j2.ins_nl,
                 held_valid && j1.emit, held_valid && j1.ins_nl};
    grp       = '0;
    pos       = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && pos < 3'(MAX_RESULTS)) begin
        grp.chars[pos[1:0]] = cand_char[i];
        grp.cv[pos[1:0]]    = cand_cv[i];
        pos                 = pos + 3'd1;
      end
    end
    grp.n     = RES_CNT_BITS'(pos);
    grp.done  = ir_eof;
    grp.total = seen_ext[31:0];
    grp.kept  = kept_ext[31:0];
  end

  // Take the registered item when its results fit into the output buffer
  assign fire     = ir_valid && (grp.n == '0 || load_ok);
  assign grp_load = fire && grp.n != '0;
  assign in_ready = !ir_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ir_valid <= 1'b1;
    end else if (fire) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_char <= in_char;
      ir_eof  <= in_eof;
    end
  end

  // Advance scan state; return to reset after a file ends
  always_ff @(posedge clk) begin
    if (rst || (fire && ir_eof)) begin
      held_char  <= '0;
      held_valid <= 1'b0;
      scan       <= '{before_char: CH_SPACE, mode: CM_NONE, last_was_brace: 1'b0};
      bytes_seen <= '0;
      bytes_kept <= '0;
    end else if (fire) begin
      held_char  <= ir_char;
      held_valid <= 1'b1;
      scan       <= s1;
      bytes_seen <= bytes_seen_next;
      bytes_kept <= bytes_kept_next;
    end
  end

`ifndef SYNTH
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    scan.mode == CM_NONE || scan.mode == CM_LINE || scan.mode == CM_BLOCK)
    else $error("comment mode holds an unused code");

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    fire && ir_eof |=> !held_valid && bytes_seen == '0 && bytes_kept == '0)
    else $error("scan state not cleared after end of file");

  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    fire && !ir_eof |=> held_valid && held_char == $past(ir_char))
    else $error("lookahead byte not held");
`endif

endmodule

FILE: sv/jcws_outbuf.sv
// ----------------------------------------------------------------------------
// jcws_outbuf: result group register
// Holds up to four results of one item and drains one per cycle while ready;
// a new group loads when empty or as the current one's last result leaves.
// ----------------------------------------------------------------------------
module jcws_outbuf import jcws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  jcws_group_t grp,
  input  logic        grp_load,
  output logic        load_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        last_of_run,
  output logic        file_done,
  output logic [31:0] total_count,
  output logic [31:0] kept_count
);

  logic [MAX_RESULTS-1:0][7:0] slot_char;
  logic [MAX_RESULTS-1:0]      slot_cv;
  logic [RES_CNT_BITS-1:0]     rem;
  logic                        done;
  logic [31:0]                 total;
  logic [31:0]                 kept;
  logic                        pop;

  assign out_valid = rem != '0;
  assign pop       = out_valid && out_ready;
  assign load_ok   = rem == '0 || (rem == RES_CNT_BITS'(1) && out_ready);

  // Present slot 0; counts only on the item that closes a file
  assign out_char    = slot_char[0];
  assign char_valid  = slot_cv[0];
  assign last_of_run = rem == RES_CNT_BITS'(1);
  assign file_done   = last_of_run && done;
  assign total_count = file_done ? total : '0;
  assign kept_count  = file_done ? kept : '0;

  // Result count
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (grp_load) begin
      rem <= grp.n;
    end else if (pop) begin
      rem <= rem - RES_CNT_BITS'(1);
    end
  end

  // Load a group, or shift the slots down as each item leaves
  always_ff @(posedge clk) begin
    if (grp_load) begin
      slot_char <= grp.chars;
      slot_cv   <= grp.cv;
      done      <= grp.done;
      total     <= grp.total;
      kept      <= grp.kept;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot_char[i] <= slot_char[i+1];
        slot_cv[i]   <= slot_cv[i+1];
      end
    end
  end

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= RES_CNT_BITS'(MAX_RESULTS))
    else $error("result count beyond slot depth");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(rem))
    else $error("result count moved while output stalled");

  a_count_item: assert property (@(posedge clk) disable iff (rst)
    file_done |-> !char_valid && out_char == CH_NUL)
    else $error("file close item carries a character");
`endif

endmodule

FILE: tb/jcws_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jcws_tb_pkg: expected-output tracker for the script stripper testbench
// Mirrors the stripper's byte-by-byte behavior, queues the bytes and count
// items that each accepted input byte should produce, and checks results.
// ----------------------------------------------------------------------------
package jcws_tb_pkg;
  import jcws_pkg::*;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        char_valid;
    logic        last_of_run;
    logic        file_done;
    logic [31:0] total_count;
    logic [31:0] kept_count;
  } strip_result_t;

  class strip_scoreboard;
    logic [7:0]    held_char;
    bit            held_valid;
    logic [7:0]    prev_char;
    cmode_t        mode;
    bit            brace_out;
    logic [31:0]   seen_cnt;
    logic [31:0]   kept_cnt;
    strip_result_t stripped_q[$];
    int            errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      held_char  = CH_NUL;
      held_valid = 1'b0;
      prev_char  = CH_SPACE;
      mode       = CM_NONE;
      brace_out  = 1'b0;
      seen_cnt   = '0;
      kept_cnt   = '0;
    endfunction

    function bit alnum_byte(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    endfunction

    function bit word_byte(logic [7:0] c);
      return alnum_byte(c) || c == CH_UNDER || c == CH_PLUS || c == CH_DOLLAR ||
             c == CH_BSLASH || c > CH_ASCII_TOP;
    endfunction

    // Saturate at the all-ones count
    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function void push_byte(logic [7:0] c);
      strip_result_t r;
      r = '{out_char: c, char_valid: 1'b1, last_of_run: 1'b0, file_done: 1'b0,
            total_count: '0, kept_count: '0};
      stripped_q.insert(stripped_q.size(), r);
    endfunction

    // Decide one byte with its lookahead byte
    function void scan_byte(logic [7:0] cur, logic [7:0] nxt);
      logic [7:0] prev;
      bit         skip;
      prev = prev_char;
      if (mode == CM_NONE && cur == CH_SLASH) begin
        if (nxt == CH_SLASH) begin
          mode = CM_LINE;
        end else if (nxt == CH_STAR) begin
          mode = CM_BLOCK;
        end
      end
      if (mode == CM_NONE) begin
        skip = (cur == CH_SPACE && nxt == CH_SPACE);
        if (!skip && cur != CH_LF && cur != CH_CR && cur != CH_TAB) begin
          if (cur == CH_SPACE && (!word_byte(nxt) || !word_byte(prev))) begin
            skip = 1'b1;
          end
          if (!skip) begin
            if (brace_out && alnum_byte(cur)) begin
              push_byte(CH_LF);
            end
            brace_out = (cur == CH_RBRACE);
            push_byte(cur);
            kept_cnt = bump(kept_cnt);
          end
        end
      end
      if (mode == CM_LINE && cur == CH_LF) begin
        mode = CM_NONE;
      end
      if (mode == CM_BLOCK && cur == CH_SLASH && prev == CH_STAR) begin
        mode = CM_NONE;
      end
      prev_char = (cur == CH_LF) ? CH_SPACE : cur;
      seen_cnt  = bump(seen_cnt);
    endfunction

    // Note an accepted input byte and queue what it should produce
    function void note_input(logic [7:0] c, logic eof);
      int            first;
      strip_result_t r;
      first = stripped_q.size();
      if (held_valid) begin
        scan_byte(held_char, (held_char == CH_LF) ? CH_SPACE : c);
      end
      held_char  = c;
      held_valid = 1'b1;
      if (eof) begin
        // Flush the held byte and close the file with a trailing newline
        if (c == CH_LF) begin
          scan_byte(c, CH_SPACE);
        end else begin
          scan_byte(c, CH_LF);
          scan_byte(CH_LF, CH_SPACE);
        end
        r = '{out_char: CH_NUL, char_valid: 1'b0, last_of_run: 1'b0, file_done: 1'b1,
              total_count: seen_cnt, kept_count: kept_cnt};
        stripped_q.insert(stripped_q.size(), r);
        clear_state();
      end
      if (stripped_q.size() > first) begin
        stripped_q[stripped_q.size() - 1].last_of_run = 1'b1;
      end
    endfunction

    // Compare one output item against the oldest queued one
    function void check_result(strip_result_t got);
      strip_result_t want;
      if (stripped_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: char %h cv %b last %b done %b total %0d kept %0d",
                 $time, got.out_char, got.char_valid, got.last_of_run, got.file_done,
                 got.total_count, got.kept_count);
        return;
      end
      want = stripped_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch: expected char %h cv %b last %b done %b total %0d kept %0d",
                 $time, want.out_char, want.char_valid, want.last_of_run, want.file_done,
                 want.total_count, want.kept_count);
        $display("%0t:           actual   char %h cv %b last %b done %b total %0d kept %0d",
                 $time, got.out_char, got.char_valid, got.last_of_run, got.file_done,
                 got.total_count, got.kept_count);
      end
    endfunction

    function int pending();
      return stripped_q.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream test of the script comment and whitespace stripper
// Sends directed and random script files byte by byte with random gaps and
// output stalls, and checks every output item against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import jcws_pkg::*;
  import jcws_tb_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int STALL_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jcws_in_if  in_if ();
  jcws_out_if out_if ();

  js_comment_whitespace_stripper_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  strip_scoreboard sb;
  bit              send_gaps = 1'b1;
  bit              recv_gaps = 1'b1;
  logic [7:0]      text_q[$];
  int              quiet_cycles = 0;
  int              sent = 0;

  always #5 clk = ~clk;

  // Drive output ready, stalling at random when allowed
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= !(recv_gaps && $urandom_range(0, 99) < 35);
    end
  end

  // Check every accepted output item
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      sb.check_result('{out_char: out_if.out_char, char_valid: out_if.char_valid,
                        last_of_run: out_if.last_of_run, file_done: out_if.file_done,
                        total_count: out_if.total_count, kept_count: out_if.kept_count});
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[js_comment_whitespace_stripper_top] ERROR");
      $finish;
    end
  end

  // Send one byte, idling at random before it
  task automatic send_item(input logic [7:0] c, input logic eof);
    while (send_gaps && $urandom_range(0, 99) < 35) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.in_char     <= c;
    in_if.end_of_file <= eof;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(c, eof);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  // Hold input until every queued result has drained
  task automatic drain_outputs();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_alnum();
    int k;
    k = $urandom_range(0, 61);
    if (k < 26) return 8'(int'("a") + k);
    if (k < 52) return 8'(int'("A") + k - 26);
    return 8'(int'("0") + k - 52);
  endfunction

  function automatic logic [7:0] pick_printable();
    return 8'($urandom_range(32, 126));
  endfunction

  // Append one byte to the file under construction
  function automatic void add_text(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  // Build one random file from script-like fragments plus noise
  task automatic make_file();
    string punct;
    int    target;
    int    pick;
    int    n;
    punct  = "(){};=.,*/+-$_\\";
    target = ($urandom_range(0, 99) < 6) ? 1 : $urandom_range(3, 25);
    text_q.delete();
    while (text_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        n = $urandom_range(1, 5);
        repeat (n) add_text(pick_alnum());
      end else if (pick < 40) begin
        n = $urandom_range(1, 3);
        repeat (n) add_text(CH_SPACE);
      end else if (pick < 48) begin
        add_text(CH_SLASH);
        add_text(CH_SLASH);
        n = $urandom_range(0, 4);
        repeat (n) add_text(pick_printable());
        add_text(CH_LF);
      end else if (pick < 56) begin
        add_text(CH_SLASH);
        add_text(CH_STAR);
        n = $urandom_range(0, 4);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: add_text(CH_STAR);
            1: add_text(CH_SLASH);
            default: add_text(pick_printable());
          endcase
        end
        add_text(CH_STAR);
        add_text(CH_SLASH);
      end else if (pick < 64) begin
        add_text(CH_RBRACE);
      end else if (pick < 74) begin
        case ($urandom_range(0, 2))
          0: add_text(CH_LF);
          1: add_text(CH_CR);
          default: add_text(CH_TAB);
        endcase
      end else if (pick < 84) begin
        add_text(punct[$urandom_range(0, punct.len() - 1)]);
      end else if (pick < 92) begin
        add_text(8'($urandom_range(127, 255)));
      end else begin
        add_text(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int goal;
    sb = new();
    in_if.valid       <= 1'b0;
    in_if.in_char     <= CH_NUL;
    in_if.end_of_file <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: double spaces, comments, brace newline, control bytes
    send_text("a  +b}c/*/x*/ \t\r//q\n");
    // Directed: high bytes around a space, brace then digit, lone NUL file
    send_item(8'h80, 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_RBRACE, 1'b0);
    send_item("7", 1'b1);
    send_item(CH_NUL, 1'b1);

    drain_outputs();

    // Random files, with one stretch free of gaps and stalls
    goal = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      send_gaps = !(sent > goal - 140 && sent < goal - 80);
      recv_gaps = send_gaps;
      make_file();
      for (int i = 0; i < text_q.size(); i++) begin
        send_item(text_q[i], i == text_q.size() - 1);
      end
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;

    drain_outputs();
    if (sb.errors == 0) begin
      $display("[js_comment_whitespace_stripper_top] OK");
    end else begin
      $display("[js_comment_whitespace_stripper_top] ERROR");
    end
    $finish;
  end

endmodule
